/* rtl/lps_pkg.sv */
// Package for the lifetime pool spawner: shared constants, register codes,
// command codes and the sequencer state type. No dependencies.
package lps_pkg;

  localparam int POOL_SIZE_DEF = 64;

  localparam int LIFE_W   = 16;
  localparam int ELAP_W   = 16;
  localparam int TIMER_W  = 17;
  localparam int COUNT_W  = 7;
  localparam int DROP_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIMER_W - 1);

  localparam logic [CFG_W-1:0] SPAWN_INTERVAL_RST    = 16'd200;
  localparam logic [CFG_W-1:0] PARTICLE_LIFETIME_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAWN_INTERVAL    = 2'd0,
    REG_PARTICLE_LIFETIME = 2'd1,
    REG_EMITTER_ENABLED   = 2'd2,
    REG_PAUSED            = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_WALK_FIX,
    ST_TIMER,
    ST_DIV,
    ST_SPAWN_RD,
    ST_SPAWN_WR,
    ST_DONE
  } state_t;

endpackage

/* rtl/lps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lifetime_pool_spawner.sv */
// Top level of the lifetime pool spawner: sequencer over the link and
// lifetime memories. Depends on lps_pkg and lps_ram.
//
// After reset an initialization pass links every slot into the free list
// (busy stays high, configuration writes are still taken).
// A clear moves each active slot onto the free stack. A tick walks the active list,
// ages each surviving slot and frees each expiring one, splicing its predecessor (if any)
// past it; a paused tick does neither. With emission enabled and a nonzero timer a
// 17-step divider then sets the spawn count, and each spawn takes a slot off the free stack.
// The result strobe done is high for one cycle and cannot be held off; one item at a time.
module lifetime_pool_spawner #(
  parameter int POOL_SIZE = lps_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [lps_pkg::ELAP_W-1:0]    elapsed,
  output logic                          done,
  output logic [lps_pkg::COUNT_W-1:0]   active_count,
  output logic [lps_pkg::COUNT_W-1:0]   expired_count,
  output logic [lps_pkg::COUNT_W-1:0]   spawned_count,
  output logic [lps_pkg::DROP_W-1:0]    dropped_spawns,
  output logic                          pool_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_W-1:0]     cfg_data
);

  import lps_pkg::*;

  localparam int SW = $clog2(POOL_SIZE + 1);
  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [SW-1:0] NIL = SW'(POOL_SIZE);
  localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SIZE - 1);

  state_t state, state_next;

  logic [SW-1:0]       cur, cur_next;
  logic [SW-1:0]       prev, prev_next;
  logic [SW-1:0]       free_head, free_head_next;
  logic [SW-1:0]       active_head, active_head_next;
  logic [SW-1:0]       active_total, active_total_next;
  logic [SW-1:0]       expired, expired_next;
  logic [SW-1:0]       spawned, spawned_next;
  logic [TIMER_W-1:0]  spawn_timer, spawn_timer_next;
  logic [TIMER_W-1:0]  quo, quo_next;
  logic [LIFE_W-1:0]   rem, rem_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [DROP_W-1:0]   dropped, dropped_next;
  logic [ELAP_W-1:0]   elapsed_r;

  logic [CFG_W-1:0]    spawn_interval, particle_lifetime;
  logic                emitter_enabled, paused;

  logic                link_we;
  logic [AW-1:0]       link_waddr, link_raddr;
  logic [SW-1:0]       link_wdata, link_rdata;
  logic                life_we;
  logic [AW-1:0]       life_waddr, life_raddr;
  logic [LIFE_W-1:0]   life_wdata, life_rdata;

  logic                accept;
  logic [CFG_W-1:0]    iv;
  logic [TIMER_W-1:0]  timer_sum;
  logic [TIMER_W-1:0]  div_trial;
  logic                div_bit;
  logic [LIFE_W-1:0]   rem_step;
  logic [DROP_W+1:0]   drop_sum;

  lps_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  lps_ram #(.WIDTH(LIFE_W), .DEPTH(POOL_SIZE)) u_life_ram (
    .clk   (clk),
    .we    (life_we),
    .waddr (life_waddr),
    .wdata (life_wdata),
    .raddr (life_raddr),
    .rdata (life_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign iv        = (spawn_interval == '0) ? CFG_W'(1) : spawn_interval;
  assign timer_sum = spawn_timer + TIMER_W'(elapsed_r);
  // One restoring division step on the running remainder.
  assign div_trial = {rem, quo[TIMER_W-1]};
  assign div_bit   = (div_trial >= TIMER_W'(iv));
  assign rem_step  = div_bit ? LIFE_W'(div_trial - TIMER_W'(iv)) : div_trial[LIFE_W-1:0];
  assign drop_sum  = (DROP_W+2)'(dropped) + (DROP_W+2)'(quo);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:      if (cur == LAST_SLOT) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_CLEAR) begin
            state_next = (active_head == NIL) ? ST_DONE : ST_CLR_RD;
          end else if (paused) begin
            state_next = ST_DONE;
          end else begin
            state_next = (active_head == NIL) ? ST_TIMER : ST_WALK_RD;
          end
        end
      end
      ST_CLR_RD:    state_next = ST_CLR_WR;
      ST_CLR_WR:    state_next = (link_rdata == NIL) ? ST_DONE : ST_CLR_RD;
      ST_WALK_RD:   state_next = ST_WALK_EVAL;
      ST_WALK_EVAL: begin
        if (life_rdata <= elapsed_r && prev != NIL) begin
          state_next = ST_WALK_FIX;
        end else begin
          state_next = (link_rdata == NIL) ? ST_TIMER : ST_WALK_RD;
        end
      end
      ST_WALK_FIX:  state_next = (cur == NIL) ? ST_TIMER : ST_WALK_RD;
      ST_TIMER: begin
        if (!emitter_enabled || timer_sum == '0) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV:       if (div_cnt == DIV_LAST) state_next = ST_SPAWN_RD;
      ST_SPAWN_RD: begin
        if (quo == '0 || free_head == NIL) state_next = ST_DONE;
        else state_next = ST_SPAWN_WR;
      end
      ST_SPAWN_WR:  state_next = ST_SPAWN_RD;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cur_next          = cur;
    prev_next         = prev;
    free_head_next    = free_head;
    active_head_next  = active_head;
    active_total_next = active_total;
    expired_next      = expired;
    spawned_next      = spawned;
    spawn_timer_next  = spawn_timer;
    quo_next          = quo;
    rem_next          = rem;
    div_cnt_next      = div_cnt;
    dropped_next      = dropped;
    link_we    = 1'b0;
    link_waddr = cur[AW-1:0];
    link_wdata = free_head;
    link_raddr = cur[AW-1:0];
    life_we    = 1'b0;
    life_waddr = cur[AW-1:0];
    life_wdata = life_rdata - elapsed_r;
    life_raddr = cur[AW-1:0];
    unique case (state)
      ST_INIT: begin
        link_we    = 1'b1;
        link_wdata = cur + SW'(1);
        cur_next   = cur + SW'(1);
      end
      ST_IDLE: begin
        expired_next = '0;
        spawned_next = '0;
        prev_next    = NIL;
        cur_next     = active_head;
      end
      ST_CLR_RD: ;
      ST_CLR_WR: begin
        // Move the head slot onto the free stack.
        link_we          = 1'b1;
        free_head_next   = cur;
        active_head_next = link_rdata;
        cur_next         = link_rdata;
        if (link_rdata == NIL) active_total_next = '0;
      end
      ST_WALK_RD: ;
      ST_WALK_EVAL: begin
        cur_next = link_rdata;
        if (life_rdata <= elapsed_r) begin
          link_we        = 1'b1;
          free_head_next = cur;
          expired_next   = expired + SW'(1);
          if (active_total != '0) active_total_next = active_total - SW'(1);
          if (prev == NIL) active_head_next = link_rdata;
        end else begin
          life_we   = 1'b1;
          prev_next = cur;
        end
      end
      ST_WALK_FIX: begin
        // Splice the predecessor past the expired slot; cur already holds its successor.
        link_we    = 1'b1;
        link_waddr = prev[AW-1:0];
        link_wdata = cur;
      end
      ST_TIMER: begin
        quo_next     = timer_sum - TIMER_W'(1);
        rem_next     = '0;
        div_cnt_next = '0;
        if (emitter_enabled && timer_sum == '0) spawn_timer_next = '0;
      end
      ST_DIV: begin
        quo_next     = {quo[TIMER_W-2:0], div_bit};
        rem_next     = rem_step;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        // The timer keeps ((sum - 1) mod interval) + 1.
        if (div_cnt == DIV_LAST) spawn_timer_next = TIMER_W'(rem_step) + TIMER_W'(1);
      end
      ST_SPAWN_RD: begin
        link_raddr = free_head[AW-1:0];
        life_waddr = free_head[AW-1:0];
        life_wdata = particle_lifetime;
        if (quo != '0) begin
          if (free_head == NIL) begin
            dropped_next = drop_sum > (DROP_W+2)'({DROP_W{1'b1}}) ?
                           {DROP_W{1'b1}} : drop_sum[DROP_W-1:0];
            quo_next     = '0;
          end else begin
            life_we = 1'b1;
          end
        end
      end
      ST_SPAWN_WR: begin
        link_we           = 1'b1;
        link_waddr        = free_head[AW-1:0];
        link_wdata        = active_head;
        active_head_next  = free_head;
        free_head_next    = link_rdata;
        active_total_next = active_total + SW'(1);
        spawned_next      = spawned + SW'(1);
        quo_next          = quo - TIMER_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_INIT;
      cur               <= '0;
      prev              <= NIL;
      free_head         <= '0;
      active_head       <= NIL;
      active_total      <= '0;
      expired           <= '0;
      spawned           <= '0;
      spawn_timer       <= '0;
      dropped           <= '0;
      spawn_interval    <= SPAWN_INTERVAL_RST;
      particle_lifetime <= PARTICLE_LIFETIME_RST;
      emitter_enabled   <= 1'b1;
      paused            <= 1'b0;
    end else begin
      state        <= state_next;
      cur          <= cur_next;
      prev         <= prev_next;
      free_head    <= free_head_next;
      active_head  <= active_head_next;
      active_total <= active_total_next;
      expired      <= expired_next;
      spawned      <= spawned_next;
      spawn_timer  <= spawn_timer_next;
      dropped      <= dropped_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SPAWN_INTERVAL:    spawn_interval    <= cfg_data;
          REG_PARTICLE_LIFETIME: particle_lifetime <= cfg_data;
          REG_EMITTER_ENABLED:   emitter_enabled   <= cfg_data[0];
          REG_PAUSED:            paused            <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    quo     <= quo_next;
    rem     <= rem_next;
    div_cnt <= div_cnt_next;
    if (accept) begin
      elapsed_r <= elapsed;
    end
  end

  assign done           = (state == ST_DONE);
  assign active_count   = COUNT_W'(active_total);
  assign expired_count  = COUNT_W'(expired);
  assign spawned_count  = COUNT_W'(spawned);
  assign dropped_spawns = dropped;
  assign pool_full      = (free_head == NIL);

endmodule

/* rtl/lps_checker.sv */
// Port-level checker for the lifetime pool spawner, bound to the top level.
// Depends on lps_pkg.
module lps_checker #(
  parameter int POOL_SIZE = lps_pkg::POOL_SIZE_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lps_pkg::COUNT_W-1:0]   active_count,
  input logic                          pool_full
);

  import lps_pkg::*;

  // A result comes from a busy block and lasts one cycle.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // An empty free list means every slot is active.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && pool_full) |-> (active_count == COUNT_W'(POOL_SIZE)))
    else $error("pool full but active count disagrees");

endmodule

bind lifetime_pool_spawner lps_checker #(.POOL_SIZE(POOL_SIZE)) u_lps_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .active_count (active_count),
  .pool_full    (pool_full)
);
